[hdl/two_stage_boxcar_extrapolator_top_defines.svh]
// Assertion macros for the two-stage box-car extrapolator.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TWO_STAGE_BOXCAR_EXTRAPOLATOR_TOP_DEFINES_SVH
`define TWO_STAGE_BOXCAR_EXTRAPOLATOR_TOP_DEFINES_SVH

// condition holds in the same cycle
`define TSBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the antecedent
`define TSBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tsbe_pkg.sv]
// Shared types and constants of the two-stage box-car extrapolator.
// No dependencies.
package tsbe_pkg;

  localparam int SAMPLE_BITS_D  = 24;
  localparam int FIRST_DEPTH_D  = 256;
  localparam int SECOND_DEPTH_D = 256;
  localparam int EXTRAP_DEPTH_D = 64;

  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEN2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LENE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 3'd5;

  localparam logic [22:0] CLIP_RST = 23'h7FFFFF;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_BYP, ST_PINIT, ST_PFILL, ST_SUM1, ST_DIV1S, ST_DIV1,
    ST_SUM2, ST_DIV2S, ST_DIV2, ST_EXT, ST_MUL, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic bypass;
    logic prime_init;
    logic sweep_run;
    logic sweep_zero;
    logic sum1;
    logic div_start;
    logic div_sel2;
    logic sum2;
    logic ext_wr;
    logic mul;
    logic fin;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic in_cmd;
    logic enable;
    logic sweep_last;
    logic sweep_idle;
    logic div_done;
  } sts_t;

endpackage

[hdl/tsbe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on tsbe_pkg for default sizes.
module tsbe_ram #(
  parameter int W = tsbe_pkg::SAMPLE_BITS_D,
  parameter int D = tsbe_pkg::FIRST_DEPTH_D
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tsbe_div.sv]
// Iterative restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on tsbe_pkg.
module tsbe_div #(
  parameter int NW = 33,
  parameter int DW = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] dividend,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic signed [NW-1:0] quotient
);
  import tsbe_pkg::*;

  localparam int CNW = $clog2(NW + 1);

  logic [NW-1:0]  num_r;
  logic [DW-1:0]  rem_r;
  logic [DW-1:0]  den_r;
  logic           neg_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic [DW:0]    trial;
  logic           qbit;

  assign trial = {rem_r, num_r[NW-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNW'(NW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
      neg_r <= dividend[NW-1];
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      num_r <= {num_r[NW-2:0], qbit};
    end
  end

  assign done     = !busy_r;
  assign quotient = neg_r ? -$signed(num_r) : $signed(num_r);

endmodule

[hdl/tsbe_dp.sv]
// Datapath: config registers, clip, ring memories, running sums, divider,
// extrapolation multiply and result registers. Depends on tsbe_pkg, tsbe_ram, tsbe_div.
module tsbe_dp #(
  parameter int SB = tsbe_pkg::SAMPLE_BITS_D,
  parameter int FD = tsbe_pkg::FIRST_DEPTH_D,
  parameter int SD = tsbe_pkg::SECOND_DEPTH_D,
  parameter int ED = tsbe_pkg::EXTRAP_DEPTH_D
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tsbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsbe_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_cmd,
  input  logic signed [SB-1:0]              in_sample,
  input  tsbe_pkg::ctl_t                    ctl,
  output tsbe_pkg::sts_t                    sts,
  output logic signed [SB-1:0]              out_filtered,
  output logic signed [SB-1:0]              out_extrapolated
);
  import tsbe_pkg::*;

  localparam int A1   = $clog2(FD);
  localparam int A2   = $clog2(SD);
  localparam int AE   = $clog2(ED);
  localparam int L1W  = $clog2(FD + 1);
  localparam int L2W  = $clog2(SD + 1);
  localparam int LW   = (L1W > L2W) ? L1W : L2W;
  localparam int MD12 = (FD > SD) ? FD : SD;
  localparam int MAXD = (MD12 > ED) ? MD12 : ED;
  localparam int CW   = $clog2(MAXD);
  localparam int S1W  = SB + $clog2(FD) + 1;
  localparam int S2W  = SB + $clog2(SD) + 1;
  localparam int NW   = SB + $clog2(MD12) + 1;
  localparam int PW   = SB + 18;

  function automatic logic signed [SB-1:0] sat_f(input logic signed [63:0] v);
    logic signed [63:0] mx;
    logic signed [63:0] mn;
    mx = (64'sd1 <<< (SB - 1)) - 64'sd1;
    mn = -mx - 64'sd1;
    if (v > mx) return SB'(mx);
    if (v < mn) return SB'(mn);
    return SB'(v);
  endfunction

  logic                  en_r;
  logic [8:0]            len1_r, len2_r;
  logic [6:0]            lene_r;
  logic [15:0]           fac_r;
  logic [22:0]           clip_r;

  logic [L1W-1:0]        l1;
  logic [L2W-1:0]        l2;
  logic [AE:0]           le;

  logic signed [SB-1:0]  x_r, s_r, filt_r, ext_r, old_r, out_f_r, out_e_r;
  logic signed [S1W-1:0] sum1_r;
  logic signed [S2W-1:0] sum2_r;
  logic [A1-1:0]         pos1_r;
  logic [A2-1:0]         pos2_r;
  logic [AE-1:0]         pose_r;
  logic [CW-1:0]         sw_r;
  logic signed [PW-1:0]  prod_r;

  logic signed [63:0]    s_w, lim_w, x_w, smax_w;
  logic signed [SB-1:0]  fill;
  logic [SB-1:0]         rd1, rd2, rde;
  logic                  we1, we2, wee;
  logic [A1-1:0]         wa1;
  logic [A2-1:0]         wa2;
  logic [AE-1:0]         wae;
  logic [SB-1:0]         wd1, wd2, wde;
  logic signed [NW-1:0]  div_q;
  logic signed [SB-1:0]  q_sat;
  logic signed [SB:0]    diff;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      len1_r <= 9'd1;
      len2_r <= 9'd1;
      lene_r <= 7'd1;
      fac_r  <= '0;
      clip_r <= CLIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: en_r   <= cfg_data[0];
        REG_LEN1:   len1_r <= cfg_data[8:0];
        REG_LEN2:   len2_r <= cfg_data[8:0];
        REG_LENE:   lene_r <= cfg_data[6:0];
        REG_FACTOR: fac_r  <= cfg_data[15:0];
        REG_CLIP:   clip_r <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // effective lengths
  always_comb begin
    if (len1_r == '0) l1 = L1W'(1);
    else if (32'(len1_r) > 32'(FD)) l1 = L1W'(FD);
    else l1 = L1W'(len1_r);
    if (len2_r == '0) l2 = L2W'(1);
    else if (32'(len2_r) > 32'(SD)) l2 = L2W'(SD);
    else l2 = L2W'(len2_r);
    if (lene_r == '0) le = (AE + 1)'(1);
    else if (32'(lene_r) > 32'(ED)) le = (AE + 1)'(ED);
    else le = (AE + 1)'(lene_r);
  end

  // clip
  always_comb begin
    s_w    = 64'(in_sample);
    smax_w = (64'sd1 <<< (SB - 1)) - 64'sd1;
    lim_w  = (64'(clip_r) > smax_w) ? smax_w : 64'(clip_r);
    if (s_w > lim_w) x_w = lim_w;
    else if (s_w < -lim_w) x_w = -lim_w;
    else x_w = s_w;
  end

  assign q_sat = sat_f(64'(div_q));
  assign fill  = ctl.sweep_zero ? '0 : x_r;
  assign diff  = (SB + 1)'(filt_r) - (SB + 1)'(old_r);

  // ring ports
  always_comb begin
    we1 = (ctl.sweep_run && (32'(sw_r) < 32'(FD))) || ctl.sum1;
    wa1 = ctl.sweep_run ? A1'(sw_r) : pos1_r;
    wd1 = ctl.sweep_run ? ((32'(sw_r) < 32'(l1)) ? fill : '0) : x_r;
    we2 = (ctl.sweep_run && (32'(sw_r) < 32'(SD))) || ctl.sum2;
    wa2 = ctl.sweep_run ? A2'(sw_r) : pos2_r;
    wd2 = ctl.sweep_run ? ((32'(sw_r) < 32'(l2)) ? fill : '0) : q_sat;
    wee = (ctl.sweep_run && (32'(sw_r) < 32'(ED))) || ctl.ext_wr;
    wae = ctl.sweep_run ? AE'(sw_r) : pose_r;
    wde = ctl.sweep_run ? fill : q_sat;
  end

  tsbe_ram #(.W(SB), .D(FD)) u_ring1 (
    .clk(clk), .we(we1), .waddr(wa1), .wdata(wd1), .raddr(pos1_r), .rdata(rd1)
  );
  tsbe_ram #(.W(SB), .D(SD)) u_ring2 (
    .clk(clk), .we(we2), .waddr(wa2), .wdata(wd2), .raddr(pos2_r), .rdata(rd2)
  );
  tsbe_ram #(.W(SB), .D(ED)) u_ringe (
    .clk(clk), .we(wee), .waddr(wae), .wdata(wde), .raddr(pose_r), .rdata(rde)
  );

  tsbe_div #(.NW(NW), .DW(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (ctl.div_sel2 ? NW'(sum2_r) : NW'(sum1_r)),
    .divisor  (ctl.div_sel2 ? LW'(l2) : LW'(l1)),
    .done     (sts.div_done),
    .quotient (div_q)
  );

  // control-side state: sums, positions, sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum1_r <= '0;
      sum2_r <= '0;
      pos1_r <= '0;
      pos2_r <= '0;
      pose_r <= '0;
      sw_r   <= '0;
    end else begin
      if (ctl.sweep_run) begin
        sw_r <= (sw_r == CW'(MAXD - 1)) ? '0 : sw_r + 1'b1;
      end
      if (ctl.prime_init) begin
        sum1_r <= S1W'($signed({1'b0, l1})) * S1W'(x_r);
        sum2_r <= S2W'($signed({1'b0, l2})) * S2W'(x_r);
        pos1_r <= '0;
        pos2_r <= '0;
        pose_r <= '0;
      end
      if (ctl.sum1) begin
        sum1_r <= sum1_r + S1W'(x_r) - S1W'($signed(rd1));
        pos1_r <= (32'(pos1_r) + 32'd1 >= 32'(l1)) ? '0 : pos1_r + 1'b1;
      end
      if (ctl.sum2) begin
        sum2_r <= sum2_r + S2W'(q_sat) - S2W'($signed(rd2));
        pos2_r <= (32'(pos2_r) + 32'd1 >= 32'(l2)) ? '0 : pos2_r + 1'b1;
      end
      if (ctl.ext_wr) begin
        pose_r <= (32'(pose_r) + 32'd1 >= 32'(le)) ? '0 : pose_r + 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      x_r   <= SB'(x_w);
      s_r   <= in_sample;
    end
    if (ctl.bypass) begin
      filt_r <= s_r;
      ext_r  <= s_r;
    end
    if (ctl.prime_init) begin
      filt_r <= en_r ? x_r : s_r;
      ext_r  <= en_r ? x_r : s_r;
    end
    if (ctl.ext_wr) begin
      filt_r <= q_sat;
      old_r  <= $signed(rde);
    end
    if (ctl.mul) begin
      prod_r <= PW'($signed({1'b0, fac_r})) * PW'(diff);
    end
    if (ctl.fin) begin
      ext_r <= sat_f(64'(filt_r) + 64'(prod_r >>> 8));
    end
    if (ctl.out_load) begin
      out_f_r <= filt_r;
      out_e_r <= ext_r;
    end
  end

  assign out_filtered     = out_f_r;
  assign out_extrapolated = out_e_r;

  assign sts.in_cmd     = in_cmd;
  assign sts.enable     = en_r;
  assign sts.sweep_last = (sw_r == CW'(MAXD - 1));
  assign sts.sweep_idle = (sw_r == '0);

endmodule

[hdl/tsbe_ctrl.sv]
// Sequencer: handshakes, ring clearing and priming sweeps, filter step order.
// Depends on tsbe_pkg.
module tsbe_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tsbe_pkg::sts_t  sts,
  output tsbe_pkg::ctl_t  ctl
);
  import tsbe_pkg::*;

  state_t state_r, state_nxt;
  logic   ovld_r, ovld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        ctl.sweep_run  = 1'b1;
        ctl.sweep_zero = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (sts.in_cmd) state_nxt = ST_PINIT;
          else if (!sts.enable) state_nxt = ST_BYP;
          else state_nxt = ST_SUM1;
        end
      end
      ST_BYP: begin
        ctl.bypass = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_PINIT: begin
        ctl.prime_init = 1'b1;
        state_nxt      = ST_PFILL;
      end
      ST_PFILL: begin
        ctl.sweep_run = 1'b1;
        if (sts.sweep_last) state_nxt = ST_OUT;
      end
      ST_SUM1: begin
        ctl.sum1  = 1'b1;
        state_nxt = ST_DIV1S;
      end
      ST_DIV1S: begin
        ctl.div_start = 1'b1;
        state_nxt     = ST_DIV1;
      end
      ST_DIV1: begin
        if (sts.div_done) state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        ctl.sum2  = 1'b1;
        state_nxt = ST_DIV2S;
      end
      ST_DIV2S: begin
        ctl.div_start = 1'b1;
        ctl.div_sel2  = 1'b1;
        state_nxt     = ST_DIV2;
      end
      ST_DIV2: begin
        if (sts.div_done) state_nxt = ST_EXT;
      end
      ST_EXT: begin
        ctl.ext_wr = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovld_r || out_ready) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_comb begin
    if (ctl.out_load) ovld_nxt = 1'b1;
    else if (out_ready) ovld_nxt = 1'b0;
    else ovld_nxt = ovld_r;
  end

  assign out_valid = ovld_r;

endmodule

[hdl/two_stage_boxcar_extrapolator_top.sv]
// Two-stage box-car filter with delay-cancelling extrapolation. One item is in
// work at a time. A filter beat runs the shared one-bit-per-cycle divider once
// per box-car stage; a prime beat runs a sweep that writes every ring entry
// through its memory write port. After reset a clearing pass over every ring
// entry runs before the first input beat is taken; config writes are taken
// throughout. A finished result waits in an output register while the next
// input beat is accepted.
// Depends on tsbe_pkg, tsbe_ctrl, tsbe_dp and the defines header.
`include "two_stage_boxcar_extrapolator_top_defines.svh"

module two_stage_boxcar_extrapolator_top #(
  parameter int SAMPLE_BITS  = tsbe_pkg::SAMPLE_BITS_D,
  parameter int FIRST_DEPTH  = tsbe_pkg::FIRST_DEPTH_D,
  parameter int SECOND_DEPTH = tsbe_pkg::SECOND_DEPTH_D,
  parameter int EXTRAP_DEPTH = tsbe_pkg::EXTRAP_DEPTH_D
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tsbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tsbe_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cmd,
  input  logic signed [SAMPLE_BITS-1:0]  in_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_BITS-1:0]  out_filtered,
  output logic signed [SAMPLE_BITS-1:0]  out_extrapolated
);
  import tsbe_pkg::*;

  ctl_t ctl;
  sts_t sts;

  tsbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  tsbe_dp #(
    .SB(SAMPLE_BITS), .FD(FIRST_DEPTH), .SD(SECOND_DEPTH), .ED(EXTRAP_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cmd           (in_cmd),
    .in_sample        (in_sample),
    .ctl              (ctl),
    .sts              (sts),
    .out_filtered     (out_filtered),
    .out_extrapolated (out_extrapolated)
  );

  `TSBE_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second beat taken while busy")
  `TSBE_ASSERT_NOW(a_sweep_done, in_ready, sts.sweep_idle, "input taken during ring sweep")
  `TSBE_ASSERT_NEXT(a_div_busy, ctl.div_start, !sts.div_done, "divider did not start")

endmodule
